@@ rtl/core/mbae_pkg.sv @@
// shared types, constants and helpers for the modbus ascii frame encoder
package mbae_pkg;

   // default number of trailing rtu check bytes held back and dropped
   localparam int DEFAULT_CHECK_BYTES = 2;

   // depth of the command queue between front and back
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

   // configuration register indexes
   localparam logic [0:0] CSR_STRIP_CHECK_BYTES = 1'b0;
   localparam logic [0:0] CSR_ADD_FRAMING       = 1'b1;

   // ascii codes
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] HEX_ALPHA_GAP = 8'd7;

   // character slots of one command, emitted lowest slot first
   localparam int SLOT_COUNT  = 7;
   localparam int SLOT_COLON  = 0;
   localparam int SLOT_PAY_HI = 1;
   localparam int SLOT_PAY_LO = 2;
   localparam int SLOT_LRC_HI = 3;
   localparam int SLOT_LRC_LO = 4;
   localparam int SLOT_CR     = 5;
   localparam int SLOT_LF     = 6;

   typedef logic [SLOT_COUNT-1:0] slot_mask_type;

   // one classified input beat as handed to the back end
   typedef struct packed {
      slot_mask_type mask;
      logic [7:0]    pay;
      logic [7:0]    lrc;
      logic          last;
   } cmd_type;

   // queue status seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type head;
   } cmd_head_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib > 4'd9) begin
         wide = wide + HEX_ALPHA_GAP;
      end
      return wide + CHAR_ZERO;
   endfunction

endpackage

@@ rtl/core/mbae_front.sv @@
// front end: crc delay line, running sum and colon tracking, at most one command per beat
module mbae_front #(
   parameter int CHECK_BYTES = mbae_pkg::DEFAULT_CHECK_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             strip_check_bytes,
   input  logic             add_framing,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             last_byte,
   output logic             cmd_push,
   output mbae_pkg::cmd_type cmd
);
   import mbae_pkg::*;

   localparam int HOLD_DEPTH = (CHECK_BYTES > 0) ? CHECK_BYTES : 1;
   localparam int HOLD_W     = HOLD_DEPTH * 8;
   localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

   logic [HOLD_W-1:0]  hold_line_ff,  hold_line_in;
   logic [HOLD_CW-1:0] hold_count_ff, hold_count_in;
   logic [7:0]         check_sum_ff,  check_sum_in;
   logic               start_sent_ff, start_sent_in;

   logic               strip_active;
   logic               emit;
   logic               colon;
   logic               tail;
   logic [7:0]         pay;
   logic [7:0]         sum_next;
   logic [HOLD_W+7:0]  shifted;

   always_comb begin
      strip_active  = strip_check_bytes && (CHECK_BYTES > 0);
      hold_line_in  = hold_line_ff;
      hold_count_in = hold_count_ff;
      emit          = 1'b1;
      pay           = data_byte;
      shifted       = {data_byte, hold_line_ff} >> 8;

      if (strip_active) begin
         if (hold_count_ff < HOLD_CW'(CHECK_BYTES)) begin
            // still filling the delay line
            for (int i = 0; i < HOLD_DEPTH; i++) begin
               if (hold_count_ff == HOLD_CW'(i)) begin
                  hold_line_in[i*8 +: 8] = data_byte;
               end
            end
            hold_count_in = hold_count_ff + 1'b1;
            emit          = 1'b0;
         end else begin
            // oldest held byte leaves, new byte enters at the back
            pay          = hold_line_ff[7:0];
            hold_line_in = shifted[HOLD_W-1:0];
         end
      end

      colon    = add_framing && !start_sent_ff && (emit || last_byte);
      tail     = last_byte && add_framing;
      sum_next = emit ? (check_sum_ff + pay) : check_sum_ff;

      start_sent_in = start_sent_ff | colon;
      check_sum_in  = sum_next;
      if (last_byte) begin
         hold_count_in = '0;
         check_sum_in  = '0;
         start_sent_in = 1'b0;
      end

      cmd.mask              = '0;
      cmd.mask[SLOT_COLON]  = colon;
      cmd.mask[SLOT_PAY_HI] = emit;
      cmd.mask[SLOT_PAY_LO] = emit;
      cmd.mask[SLOT_LRC_HI] = tail;
      cmd.mask[SLOT_LRC_LO] = tail;
      cmd.mask[SLOT_CR]     = tail;
      cmd.mask[SLOT_LF]     = tail;
      cmd.pay               = pay;
      cmd.lrc               = 8'h00 - sum_next;
      cmd.last              = last_byte;

      // beats that only fill the delay line produce nothing
      cmd_push = accept && (cmd.mask != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= '0;
         check_sum_ff  <= '0;
         start_sent_ff <= 1'b0;
      end else if (accept) begin
         hold_count_ff <= hold_count_in;
         check_sum_ff  <= check_sum_in;
         start_sent_ff <= start_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_line_ff <= hold_line_in;
      end
   end

endmodule

@@ rtl/core/mbae_cmd_fifo.sv @@
// short command queue between front and back, show-ahead read
module mbae_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mbae_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output logic                   full,
   output mbae_pkg::cmd_head_type head
);
   import mbae_pkg::*;

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_PTR_W:0]   count_ff,  count_in;
   logic                 do_pop;

   always_comb begin
      full       = (count_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
      head.valid = (count_ff != '0);
      head.head  = entry_ff[rd_ptr_ff];
      do_pop     = pop && head.valid;
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (CMD_PTR_W+1)'(push) - (CMD_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/mbae_back.sv @@
// back end: walks each command's character slots, one character per cycle unless stalled
module mbae_back (
   input  logic                   clock,
   input  logic                   reset,
   input  mbae_pkg::cmd_head_type head,
   output logic                   head_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic [7:0]             rsp_ascii_char,
   output logic                   rsp_run_end,
   output logic                   rsp_frame_end
);
   import mbae_pkg::*;

   logic          cur_valid_ff, cur_valid_in;
   cmd_type       cur_ff, cur_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_char_ff, out_char_in;
   logic          out_run_end_ff, out_run_end_in;
   logic          out_frame_end_ff, out_frame_end_in;

   logic          advance;
   logic          step;
   logic          finishing;
   slot_mask_type lowest;
   slot_mask_type remain;
   logic [7:0]    char_sel;

   always_comb begin
      lowest = cur_ff.mask & (~cur_ff.mask + 1'b1);
      remain = cur_ff.mask & ~lowest;

      if (lowest[SLOT_COLON]) begin
         char_sel = CHAR_COLON;
      end else if (lowest[SLOT_PAY_HI]) begin
         char_sel = hex_char(cur_ff.pay[7:4]);
      end else if (lowest[SLOT_PAY_LO]) begin
         char_sel = hex_char(cur_ff.pay[3:0]);
      end else if (lowest[SLOT_LRC_HI]) begin
         char_sel = hex_char(cur_ff.lrc[7:4]);
      end else if (lowest[SLOT_LRC_LO]) begin
         char_sel = hex_char(cur_ff.lrc[3:0]);
      end else if (lowest[SLOT_CR]) begin
         char_sel = CHAR_CR;
      end else begin
         char_sel = CHAR_LF;
      end

      advance   = !out_valid_ff || rsp_pop;
      step      = advance && cur_valid_ff;
      finishing = step && (remain == '0);
      head_pop  = head.valid && (!cur_valid_ff || finishing);

      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (head_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = head.head;
      end else if (finishing) begin
         cur_valid_in = 1'b0;
      end else if (step) begin
         cur_in.mask  = remain;
      end

      out_valid_in     = out_valid_ff;
      out_char_in      = out_char_ff;
      out_run_end_in   = out_run_end_ff;
      out_frame_end_in = out_frame_end_ff;
      if (step) begin
         out_valid_in     = 1'b1;
         out_char_in      = char_sel;
         out_run_end_in   = (remain == '0);
         out_frame_end_in = (remain == '0) && cur_ff.last;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end

      rsp_empty      = !out_valid_ff;
      rsp_ascii_char = out_char_ff;
      rsp_run_end    = out_run_end_ff;
      rsp_frame_end  = out_frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff           <= cur_in;
      out_char_ff      <= out_char_in;
      out_run_end_ff   <= out_run_end_in;
      out_frame_end_ff <= out_frame_end_in;
   end

endmodule

@@ rtl/core/modbus_ascii_frame_encoder.sv @@
// top level of the modbus ascii frame encoder with lrc
// rtu bytes go in one beat at a time (last_byte marks the end of a frame) and modbus
// ascii characters come out one beat at a time: an optional colon, two uppercase hex
// characters per payload byte, and at frame end with framing on the lrc as two hex
// characters and cr lf. with strip_check_bytes set, the last CHECK_BYTES bytes of each
// frame are treated as the rtu crc and dropped through a short delay line. the front
// end takes one byte per cycle while the two-entry command queue has room; the back
// end emits one character per cycle unless stalled. throughput is set by the single
// character output port. csr writes are always ready and should only be made while no
// frame is in flight.
module modbus_ascii_frame_encoder #(
   parameter int CHECK_BYTES = mbae_pkg::DEFAULT_CHECK_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   // rtu byte input
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   // ascii character output
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_ascii_char,
   output logic       rsp_run_end,
   output logic       rsp_frame_end,
   // register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_index,
   input  logic [0:0] csr_data
);
   import mbae_pkg::*;

   logic         strip_ff, strip_in;
   logic         framing_ff, framing_in;
   logic         req_accept;
   logic         cmd_push;
   cmd_type      cmd;
   logic         fifo_full;
   cmd_head_type head;
   logic         head_pop;

   // configuration registers
   always_comb begin
      csr_ready  = 1'b1;
      strip_in   = strip_ff;
      framing_in = framing_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STRIP_CHECK_BYTES: strip_in   = csr_data[0];
            CSR_ADD_FRAMING:       framing_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff   <= 1'b1;
         framing_ff <= 1'b1;
      end else begin
         strip_ff   <= strip_in;
         framing_ff <= framing_in;
      end
   end

   // input beat taken whenever the command queue has room
   assign full       = fifo_full;
   assign req_accept = push && !fifo_full;

   mbae_front #(
      .CHECK_BYTES(CHECK_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .strip_check_bytes (strip_ff),
      .add_framing       (framing_ff),
      .accept            (req_accept),
      .data_byte         (req_data_byte),
      .last_byte         (req_last_byte),
      .cmd_push          (cmd_push),
      .cmd               (cmd)
   );

   mbae_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (head_pop),
      .full     (fifo_full),
      .head     (head)
   );

   mbae_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_pop       (head_pop),
      .rsp_pop        (pop),
      .rsp_empty      (empty),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_run_end    (rsp_run_end),
      .rsp_frame_end  (rsp_frame_end)
   );

   // the end of a frame always closes the run of its beat
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_end) |-> rsp_run_end)
      else $error("frame end without run end");

   // only colon, hex digits, cr and lf ever leave the block
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_ascii_char == CHAR_COLON || rsp_ascii_char == CHAR_CR ||
                  rsp_ascii_char == CHAR_LF ||
                  (rsp_ascii_char >= 8'h30 && rsp_ascii_char <= 8'h39) ||
                  (rsp_ascii_char >= 8'h41 && rsp_ascii_char <= 8'h46)))
      else $error("illegal ascii character");

   // with framing on, a frame end beat is always the line feed
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_end && framing_ff) |-> (rsp_ascii_char == CHAR_LF))
      else $error("framed frame does not end in lf");

   // output side is empty right after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("output not empty after reset");

endmodule
